@@ rtl/core/mmr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmr_pkg
// shared types and constants of the message mailbox relay
// ----------------------------------------------------------------------------
`default_nettype none

package mmr_pkg;

  // request codes
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_POLL     = 2'd1;
  localparam logic [1:0] REQ_SEND     = 2'd2;

  // client ids handed out: 1 .. IdLimit, the reply carries 8 bits
  localparam int unsigned MaxClients = 255;
  localparam logic [7:0]  IdLimit    = 8'((MaxClients < 255) ? MaxClients : 255);

  // stored message descriptor
  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [7:0]  flag;
    logic [10:0] length;
    logic [15:0] handle;
  } desc_t;

endpackage

`default_nettype wire

@@ rtl/core/mmr_desc_mem.sv @@
// ----------------------------------------------------------------------------
// mmr_desc_mem
// descriptor store and link store, one shared read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_desc_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Aw    = 6
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output mmr_pkg::desc_t msg_rdata_o,
  output logic [Aw-1:0] link_rdata_o,
  input  logic          msg_we_i,
  input  logic [Aw-1:0] msg_waddr_i,
  input  mmr_pkg::desc_t msg_wdata_i,
  input  logic          link_we_i,
  input  logic [Aw-1:0] link_waddr_i,
  input  logic [Aw-1:0] link_wdata_i
);
  import mmr_pkg::*;

  desc_t         msg_mem  [Depth];
  logic [Aw-1:0] link_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (msg_we_i) begin
      msg_mem[msg_waddr_i] <= msg_wdata_i;
    end
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      msg_rdata_o  <= msg_mem[rd_addr_i];
      link_rdata_o <= link_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/message_mailbox_relay_unit.sv @@
// ----------------------------------------------------------------------------
// message_mailbox_relay_unit
// store-and-forward mailbox: client registration, message send and poll
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   req_type, dest_id, src_id, msg_flag,
//                                                msg_length, payload_handle
// out       output     out_valid_o / out_ready_i reply_to, reply_from, has_message,
//                                                out_flag, out_length, out_handle, dropped
//
// - one item at a time; in_ready_o is high only while the sequencer is idle
// - register: result straight away; poll: a walk of k entries, plus unlink and free
//   on a hit, where k is the number of stored messages walked in arrival order (k <= QUEUE_DEPTH)
// - send: the append, unless the queue is full, comes first, then the same walk as a poll
// - the walk is set by the single read port of the descriptor memory: one entry
//   per cycle, the next address taken straight from the registered link data
// - rst_ni clears pointers, counts and the output valid; the memories are not
//   cleared, a fill counter hands out never-used entries once the free stack is empty
// - a result waiting on out_ready_i holds only the final step of the next item
//
`default_nettype none

module message_mailbox_relay_unit #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  dest_id_i,
  input  logic [7:0]  src_id_i,
  input  logic [7:0]  msg_flag_i,
  input  logic [10:0] msg_length_i,
  input  logic [15:0] payload_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  reply_to_o,
  output logic [7:0]  reply_from_o,
  output logic        has_message_o,
  output logic [7:0]  out_flag_o,
  output logic [10:0] out_length_o,
  output logic [15:0] out_handle_o,
  output logic        dropped_o
);
  import mmr_pkg::*;

  localparam int unsigned Aw   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = Aw + 1;
  localparam logic [CntW-1:0] QdCnt = CntW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ALLOC   = 3'd1;  // read link of the free stack top
  localparam logic [2:0] ST_APPEND  = 3'd2;  // write descriptor, link after tail
  localparam logic [2:0] ST_SRCH_RD = 3'd3;  // read head entry
  localparam logic [2:0] ST_CHK     = 3'd4;  // compare one entry per cycle
  localparam logic [2:0] ST_UNLINK  = 3'd5;  // bypass the delivered entry
  localparam logic [2:0] ST_FREE    = 3'd6;  // push it on the free stack
  localparam logic [2:0] ST_DONE    = 3'd7;  // hand result to output register

  typedef struct packed {
    logic [7:0]  reply_to;
    logic [7:0]  reply_from;
    logic        has_message;
    logic [7:0]  flag;
    logic [10:0] length;
    logic [15:0] handle;
    logic        dropped;
  } result_t;

  // control state
  logic [2:0]      state_q, state_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [Aw-1:0]   head_q, head_d;
  logic [Aw-1:0]   tail_q, tail_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] fresh_q, fresh_d;       // entries never used yet start here
  logic [Aw-1:0]   free_top_q, free_top_d; // free stack linked through link memory
  logic [CntW-1:0] free_cnt_q, free_cnt_d;
  logic [Aw-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  // payload state
  desc_t         desc_q, desc_d;
  result_t       res_q, res_d;
  result_t       out_q, out_d;
  logic [Aw-1:0] cur_q, cur_d;
  logic [Aw-1:0] prev_q, prev_d;
  logic [Aw-1:0] next_q, next_d;

  // memory port
  logic          rd_en;
  logic [Aw-1:0] rd_addr;
  desc_t         msg_rdata;
  logic [Aw-1:0] link_rdata;
  logic          msg_we;
  logic [Aw-1:0] msg_waddr;
  logic          link_we;
  logic [Aw-1:0] link_waddr;
  logic [Aw-1:0] link_wdata;
  logic [Aw-1:0] slot;

  mmr_desc_mem #(
    .Depth (QUEUE_DEPTH),
    .Aw    (Aw)
  ) u_mem (
    .clk_i        (clk_i),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .msg_rdata_o  (msg_rdata),
    .link_rdata_o (link_rdata),
    .msg_we_i     (msg_we),
    .msg_waddr_i  (msg_waddr),
    .msg_wdata_i  (desc_q),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata)
  );

  // reuse a freed entry first, otherwise take the next never-used one
  assign slot = (free_cnt_q != '0) ? free_top_q : fresh_q[Aw-1:0];

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    fresh_d     = fresh_q;
    free_top_d  = free_top_q;
    free_cnt_d  = free_cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    desc_d      = desc_q;
    res_d       = res_q;
    out_d       = out_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    next_d      = next_q;

    rd_en      = 1'b0;
    rd_addr    = head_q;
    msg_we     = 1'b0;
    msg_waddr  = slot;
    link_we    = 1'b0;
    link_waddr = tail_q;
    link_wdata = slot;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          desc_d = '{dest: dest_id_i, src: src_id_i, flag: msg_flag_i,
                     length: msg_length_i, handle: payload_handle_i};
          res_d          = '0;
          res_d.reply_to = src_id_i;
          // start the walk at the head right away for a poll
          rd_en  = 1'b1;
          cur_d  = head_q;
          idx_d  = '0;
          unique case (req_type_i)
            REQ_REGISTER: begin
              if (cnt_q < IdLimit) begin
                cnt_d          = cnt_q + 8'd1;
                res_d.reply_to = cnt_q + 8'd1;
              end else begin
                res_d.reply_to = '0;
              end
              state_d = ST_DONE;
            end
            REQ_POLL: begin
              if (src_id_i == '0) begin
                state_d = ST_IDLE;
              end else if (occ_q == '0) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_CHK;
              end
            end
            REQ_SEND: begin
              if (src_id_i == '0 || dest_id_i == '0) begin
                state_d = ST_IDLE;
              end else if (occ_q == QdCnt) begin
                res_d.dropped = 1'b1;
                state_d       = ST_CHK;
              end else if (free_cnt_q != '0) begin
                state_d = ST_ALLOC;
              end else begin
                state_d = ST_APPEND;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        rd_en   = 1'b1;
        rd_addr = free_top_q;
        state_d = ST_APPEND;
      end

      ST_APPEND: begin
        msg_we    = 1'b1;
        msg_waddr = slot;
        if (occ_q != '0) begin
          link_we    = 1'b1;
          link_waddr = tail_q;
          link_wdata = slot;
        end else begin
          head_d = slot;
        end
        tail_d = slot;
        occ_d  = occ_q + CntW'(1);
        if (free_cnt_q != '0) begin
          free_top_d = link_rdata;
          free_cnt_d = free_cnt_q - CntW'(1);
        end else begin
          fresh_d = fresh_q + CntW'(1);
        end
        state_d = ST_SRCH_RD;
      end

      ST_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        cur_d   = head_q;
        idx_d   = '0;
        state_d = ST_CHK;
      end

      ST_CHK: begin
        if (msg_rdata.dest == desc_q.src) begin
          res_d.reply_from  = msg_rdata.src;
          res_d.has_message = 1'b1;
          res_d.flag        = msg_rdata.flag;
          res_d.length      = msg_rdata.length;
          res_d.handle      = msg_rdata.handle;
          next_d            = link_rdata;
          state_d           = ST_UNLINK;
        end else if (CntW'(idx_q) + CntW'(1) == occ_q) begin
          state_d = ST_DONE;
        end else begin
          // follow the link without a bubble
          rd_en   = 1'b1;
          rd_addr = link_rdata;
          prev_d  = cur_q;
          cur_d   = link_rdata;
          idx_d   = idx_q + Aw'(1);
        end
      end

      ST_UNLINK: begin
        if (cur_q == head_q) begin
          head_d = next_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q;
          link_wdata = next_q;
        end
        // removing the last entry moves the tail back
        if (cur_q == tail_q) begin
          tail_d = prev_q;
        end
        state_d = ST_FREE;
      end

      ST_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = free_top_q;
        free_top_d = cur_q;
        free_cnt_d = free_cnt_q + CntW'(1);
        occ_d      = occ_q - CntW'(1);
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      fresh_q     <= '0;
      free_top_q  <= '0;
      free_cnt_q  <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      fresh_q     <= fresh_d;
      free_top_q  <= free_top_d;
      free_cnt_q  <= free_cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    res_q  <= res_d;
    out_q  <= out_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    next_q <= next_d;
  end

  assign out_valid_o   = out_valid_q;
  assign reply_to_o    = out_q.reply_to;
  assign reply_from_o  = out_q.reply_from;
  assign has_message_o = out_q.has_message;
  assign out_flag_o    = out_q.flag;
  assign out_length_o  = out_q.length;
  assign out_handle_o  = out_q.handle;
  assign dropped_o     = out_q.dropped;

  // every entry handed out is either stored or on the free stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q == occ_q + free_cnt_q)
    else $error("entry accounting broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= QdCnt)
    else $error("occupancy above depth");

  // a delivery removes exactly one message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FREE |=> occ_q == $past(occ_q) - CntW'(1))
    else $error("delivery did not remove one message");

  // a stored message always has a nonzero source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_message_o |-> reply_from_o != '0)
    else $error("delivered message with zero source");

  // a loaded result waits until taken before the next one is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
